// ===== hdl/lcp_local_minimum_clusterer_top_assert.svh =====
// assertion macros shared by the clusterer modules
`ifndef LCP_LOCAL_MINIMUM_CLUSTERER_TOP_ASSERT_SVH
`define LCP_LOCAL_MINIMUM_CLUSTERER_TOP_ASSERT_SVH
`ifndef SYNTH
`define LCP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lcp assertion failed");
`define LCP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lcp assertion failed");
`else
`define LCP_ASSERT(label, prop)
`define LCP_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hdl/lcp_pkg.sv =====
// shared types and constants of the lcp clusterer
package lcp_pkg;

   localparam int INDEX_BITS_DEF = 40;
   localparam int LCP_BITS_DEF   = 16;
   localparam int CFG_BITS       = 16;
   localparam int LEN_BITS       = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_LCP         = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_CLUSTER_LEN = 8'd1;

   localparam logic [CFG_BITS-1:0] MIN_LCP_RESET         = 16'd16;
   localparam logic [CFG_BITS-1:0] MIN_CLUSTER_LEN_RESET = 16'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0] min_lcp;
      logic [CFG_BITS-1:0] min_cluster_len;
   } cfg_type;

   // entry1 is always the last result of its item
   typedef struct packed {
      logic [1:0] push_count;
      logic       entry0_last;
   } push_ctl_type;

endpackage

// ===== hdl/lcp_csr.sv =====
// configuration registers of the lcp clusterer
module lcp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lcp_pkg::CFG_BITS-1:0]         csr_wdata,
   output lcp_pkg::cfg_type                     cfg
);
   import lcp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_LCP:         cfg_in.min_lcp         = csr_wdata;
            REG_MIN_CLUSTER_LEN: cfg_in.min_cluster_len = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_lcp         <= MIN_LCP_RESET;
         cfg_ff.min_cluster_len <= MIN_CLUSTER_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/lcp_core.sv =====
// input register, window state and cluster decision logic
`include "lcp_local_minimum_clusterer_top_assert.svh"
module lcp_core #(
   parameter int INDEX_BITS = lcp_pkg::INDEX_BITS_DEF,
   parameter int LCP_BITS   = lcp_pkg::LCP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [LCP_BITS-1:0]           req_lcp_value,
   input  logic                          req_is_last,
   input  lcp_pkg::cfg_type              cfg,
   input  logic                          room_ok,
   output lcp_pkg::push_ctl_type         push,
   output logic [INDEX_BITS-1:0]         entry0_start,
   output logic [lcp_pkg::LEN_BITS-1:0]  entry0_len,
   output logic [INDEX_BITS-1:0]         entry1_start,
   output logic [lcp_pkg::LEN_BITS-1:0]  entry1_len
);
   import lcp_pkg::*;

   localparam int CMP_BITS = (LCP_BITS > CFG_BITS) ? LCP_BITS : CFG_BITS;

   logic                  in_valid_ff, in_valid_in;
   logic [LCP_BITS-1:0]   in_lcp_ff;
   logic                  in_last_ff;
   logic [LCP_BITS-1:0]   older_ff, older_in;
   logic [LCP_BITS-1:0]   newer_ff, newer_in;
   logic [INDEX_BITS-1:0] start_ff, start_in;
   logic                  open_ff, open_in;
   logic [INDEX_BITS-1:0] position_ff, position_in;
   logic [1:0]            fill_ff, fill_in;

   logic                  process;
   logic                  below_min;
   logic                  local_min;
   logic                  close;
   logic                  close_ok;
   logic                  opens;
   logic                  open_now;
   logic [INDEX_BITS-1:0] start_now;
   logic [INDEX_BITS-1:0] close_span;
   logic [INDEX_BITS-1:0] flush_span;
   logic [LEN_BITS-1:0]   close_len;
   logic [LEN_BITS-1:0]   flush_len;
   logic                  flush_ok;

   assign process   = in_valid_ff && room_ok;
   assign req_ready = !in_valid_ff || process;

   always_comb begin
      below_min  = CMP_BITS'(in_lcp_ff) < CMP_BITS'(cfg.min_lcp);
      local_min  = (older_ff > newer_ff) && (newer_ff <= in_lcp_ff);
      // no close test until the window holds two earlier values
      close      = (fill_ff == 2'd2) && open_ff && (local_min || below_min);
      close_span = position_ff - start_ff;
      close_len  = close_span[LEN_BITS-1:0];
      close_ok   = close && (close_len >= cfg.min_cluster_len);
      opens      = !(open_ff && !close) && !below_min;
      open_now   = (open_ff && !close) || opens;
      start_now  = opens ? position_ff : start_ff;
      flush_span = position_ff - start_now + INDEX_BITS'(1);
      flush_len  = flush_span[LEN_BITS-1:0];
      flush_ok   = in_last_ff && open_now && (flush_len >= cfg.min_cluster_len);
   end

   always_comb begin
      push.push_count  = 2'd0;
      push.entry0_last = 1'b1;
      entry0_start     = close_ok ? start_ff : start_now;
      entry0_len       = close_ok ? close_len : flush_len;
      entry1_start     = start_now;
      entry1_len       = flush_len;
      if (process) begin
         push.push_count  = {1'b0, close_ok} + {1'b0, flush_ok};
         push.entry0_last = !(close_ok && flush_ok);
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      older_in    = older_ff;
      newer_in    = newer_ff;
      start_in    = start_ff;
      open_in     = open_ff;
      position_in = position_ff;
      fill_in     = fill_ff;
      if (process) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            older_in    = '0;
            newer_in    = '0;
            start_in    = '0;
            open_in     = 1'b0;
            position_in = '0;
            fill_in     = 2'd0;
         end else begin
            older_in    = newer_ff;
            newer_in    = in_lcp_ff;
            start_in    = start_now;
            open_in     = open_now;
            position_in = position_ff + INDEX_BITS'(1);
            fill_in     = (fill_ff == 2'd2) ? fill_ff : fill_ff + 2'd1;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_lcp_ff  <= req_lcp_value;
         in_last_ff <= req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         older_ff    <= '0;
         newer_ff    <= '0;
         start_ff    <= '0;
         open_ff     <= 1'b0;
         position_ff <= '0;
         fill_ff     <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         older_ff    <= older_in;
         newer_ff    <= newer_in;
         start_ff    <= start_in;
         open_ff     <= open_in;
         position_ff <= position_in;
         fill_ff     <= fill_in;
      end
   end

   `LCP_ASSERT(a_two_only_on_last, (push.push_count == 2'd2) |-> in_last_ff)
   `LCP_ASSERT(a_last_clears_stream, (process && in_last_ff) |=> (!open_ff && position_ff == '0 && fill_ff == 2'd0))
   `LCP_ASSERT(a_fill_follows_items, (process && !in_last_ff) |=> (fill_ff != 2'd0))

endmodule

// ===== hdl/lcp_outq.sv =====
// result queue, up to two writes and one read per cycle
`include "lcp_local_minimum_clusterer_top_assert.svh"
module lcp_outq #(
   parameter int INDEX_BITS = lcp_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcp_pkg::push_ctl_type         push,
   input  logic [INDEX_BITS-1:0]         entry0_start,
   input  logic [lcp_pkg::LEN_BITS-1:0]  entry0_len,
   input  logic [INDEX_BITS-1:0]         entry1_start,
   input  logic [lcp_pkg::LEN_BITS-1:0]  entry1_len,
   output logic                          room_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_BITS-1:0]         rsp_cluster_start,
   output logic [lcp_pkg::LEN_BITS-1:0]  rsp_cluster_len,
   output logic                          rsp_last_of_run
);
   import lcp_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [INDEX_BITS-1:0] start_mem [QUEUE_DEPTH];
   logic [LEN_BITS-1:0]   len_mem   [QUEUE_DEPTH];
   logic                  last_mem  [QUEUE_DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_ptr_next;
   logic                  pop;

   // worst case of one item is two results
   assign room_ok     = count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);

   assign rsp_cluster_start = start_mem[rd_ptr_ff];
   assign rsp_cluster_len   = len_mem[rd_ptr_ff];
   assign rsp_last_of_run   = last_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push.push_count) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         start_mem[wr_ptr_ff] <= entry0_start;
         len_mem[wr_ptr_ff]   <= entry0_len;
         last_mem[wr_ptr_ff]  <= push.entry0_last;
      end
      if (push.push_count == 2'd2) begin
         start_mem[wr_ptr_next] <= entry1_start;
         len_mem[wr_ptr_next]   <= entry1_len;
         last_mem[wr_ptr_next]  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LCP_ASSERT(a_no_overflow, count_ff <= COUNT_BITS'(QUEUE_DEPTH))
   `LCP_ASSERT(a_push_needs_room, (push.push_count != 2'd0) |-> $past(room_ok) || room_ok)
   `LCP_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) |-> (count_ff == '0 && wr_ptr_ff == rd_ptr_ff))

endmodule

// ===== hdl/lcp_local_minimum_clusterer_top.sv =====
// top level of the lcp local-minimum clusterer
//
// req_ channel: one lcp value per suffix-array position, req_is_last on the
// final position of a stream; a transfer needs req_valid and req_ready high.
// rsp_ channel: one cluster per transfer (start index, length modulo 65536);
// rsp_last_of_run marks the final cluster caused by one input item. An item
// causes zero, one or two clusters (a close and the end-of-stream flush).
// csr_ channel: index 0 min_lcp, index 1 min_cluster_len, always ready;
// other indexes are dropped. Write only while the block is idle.
// A cluster reaches rsp_ from the input register of the item that closes
// it by way of the result queue. Throughput: one item per cycle while each
// item causes at most one cluster and rsp_ready stays high; the single rsp_
// port passes one cluster per cycle, so two clusters need two transfers.
// A four-entry result queue sits between the decision logic and rsp_;
// when it holds more than two clusters the input register holds its item
// and req_ready drops, so a stalled receiver backs up into req_.
// Reset (synchronous) empties the queue, clears the stream state and loads
// min_lcp = 16 and min_cluster_len = 2. req_is_last also clears the stream
// state, so a new stream may follow at once.
module lcp_local_minimum_clusterer_top #(
   parameter int INDEX_BITS = lcp_pkg::INDEX_BITS_DEF,
   parameter int LCP_BITS   = lcp_pkg::LCP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [LCP_BITS-1:0]                 req_lcp_value,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [INDEX_BITS-1:0]               rsp_cluster_start,
   output logic [lcp_pkg::LEN_BITS-1:0]        rsp_cluster_len,
   output logic                                rsp_last_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lcp_pkg::CFG_BITS-1:0]        csr_wdata
);
   import lcp_pkg::*;

   cfg_type               cfg;
   push_ctl_type          push;
   logic                  room_ok;
   logic [INDEX_BITS-1:0] entry0_start;
   logic [LEN_BITS-1:0]   entry0_len;
   logic [INDEX_BITS-1:0] entry1_start;
   logic [LEN_BITS-1:0]   entry1_len;

   lcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcp_core #(
      .INDEX_BITS (INDEX_BITS),
      .LCP_BITS   (LCP_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_lcp_value (req_lcp_value),
      .req_is_last   (req_is_last),
      .cfg           (cfg),
      .room_ok       (room_ok),
      .push          (push),
      .entry0_start  (entry0_start),
      .entry0_len    (entry0_len),
      .entry1_start  (entry1_start),
      .entry1_len    (entry1_len)
   );

   lcp_outq #(
      .INDEX_BITS (INDEX_BITS)
   ) u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .entry0_start      (entry0_start),
      .entry0_len        (entry0_len),
      .entry1_start      (entry1_start),
      .entry1_len        (entry1_len),
      .room_ok           (room_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cluster_start (rsp_cluster_start),
      .rsp_cluster_len   (rsp_cluster_len),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
